// File: design/fir_decimator_windowed_sinc_assert.svh
// Assertion macros for the FIR decimator.
// Each macro checks one implication under the block clock, held off during reset.
`ifndef FIR_DECIMATOR_WINDOWED_SINC_ASSERT_SVH
`define FIR_DECIMATOR_WINDOWED_SINC_ASSERT_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define FD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fir decimator check failed");
// Consequent must hold in the cycle after the antecedent.
`define FD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fir decimator check failed");
`else
`define FD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/fir_dec_pkg.sv
package fir_dec_pkg;

    // Input operation codes
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic start;   // clear the accumulator for a new output
        logic acc_en;  // operand pair valid this cycle
        logic last;    // operand pair is the final tap
    } t_mac_ctl;

    // Fixed-point constants for the coefficient build (Q30)
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam longint      Q30S        = 64'sd1073741824;
    localparam longint      INV_PI_Q30  = 64'sd341782638;

    // Restoring long division; returns {remainder, quotient}.
    function automatic logic [127:0] udivmod64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], a[i]};
            if (rem >= b) begin
                rem    = rem - b;
                quo[i] = 1'b1;
            end
        end
        return {rem, quo};
    endfunction

    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] qr;
        qr = udivmod64(a, b);
        return qr[63:0];
    endfunction

    function automatic logic [63:0] umod64(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] qr;
        qr = udivmod64(a, b);
        return qr[127:64];
    endfunction

    // Signed division truncating toward zero.
    function automatic longint sdiv64(input longint a, input longint b);
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] q;
        logic        neg;
        neg = (a < 0) ^ (b < 0);
        ua  = (a < 0) ? 64'(-a) : 64'(a);
        ub  = (b < 0) ? 64'(-b) : 64'(b);
        q   = udiv64(ua, ub);
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // Sine of a 32-bit fraction of a turn, Q30, Taylor series to x^13.
    function automatic longint sin_turn(input logic [31:0] p);
        logic [1:0]  quad;
        logic [63:0] f;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] r;
        quad = p[31:30];
        f    = {34'd0, p[29:0]};
        if (quad[0]) begin
            f = Q30_ONE - f;
        end
        x  = (f * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd156);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
        r  = (x * t) >> 30;
        return quad[1] ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint cos_turn(input logic [31:0] p);
        return sin_turn(p + 32'h4000_0000);
    endfunction

    // Unnormalized windowed-sinc tap i.
    function automatic longint h_tap(input int taps, input int ratio, input int i);
        longint      n;
        longint      m;
        longint      sinc;
        longint      win;
        longint      c1;
        longint      c2;
        logic [63:0] dm;
        logic [63:0] ph1;
        logic [63:0] ph2;
        logic [63:0] period;
        logic [63:0] rm;
        logic [63:0] ps;
        n   = longint'(i) - longint'(taps >>> 1);
        m   = (n < 0) ? -n : n;
        dm  = 64'(taps - 1);
        ph1 = udiv64(64'(i) << 32, dm);
        ph2 = udiv64(64'(2 * i) << 32, dm);
        if (m == 0) begin
            sinc = longint'(udiv64(64'd9 * Q30_ONE, 64'(10 * ratio)));
        end else begin
            period = 64'(20 * ratio);
            rm     = umod64(64'(9 * m), period);
            ps     = udiv64(rm << 32, period);
            sinc   = sdiv64(sin_turn(ps[31:0]) * INV_PI_Q30, m <<< 30);
        end
        c1  = cos_turn(ph1[31:0]);
        c2  = cos_turn(ph2[31:0]);
        win = (42 * Q30S - 50 * c1 + 8 * c2) / 64'sd100;
        return (sinc * win) / Q30S;
    endfunction

    function automatic longint h_sum(input int taps, input int ratio);
        longint s;
        s = 0;
        for (int i = 0; i < taps; i++) begin
            s = s + h_tap(taps, ratio, i);
        end
        if (s <= 0) begin
            s = 1;
        end
        return s;
    endfunction

    // Normalized coefficient, rounded half away from zero, saturated.
    function automatic longint coef_val(input int taps, input int ratio, input int cw,
                                        input int i, input longint sum);
        longint h;
        longint num;
        longint mag;
        longint q;
        longint lim;
        h   = h_tap(taps, ratio, i);
        num = h * (64'sd1 <<< (cw - 1));
        lim = (64'sd1 <<< (cw - 1)) - 1;
        mag = (num < 0) ? -num : num;
        q   = longint'(udiv64(64'(mag + (sum >>> 1)), 64'(sum)));
        if (q > lim + 1) begin
            q = lim + 1;
        end
        if (num < 0) begin
            q = -q;
        end
        if (q > lim) begin
            q = lim;
        end
        return q;
    endfunction

endpackage

// File: design/fir_dec_if.sv
interface fir_dec_in_if #(
    parameter int SAMPLE_WIDTH = 16
) ();
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output operation, output sample, input ready);
    modport sink   (input valid, input operation, input sample, output ready);
endinterface

interface fir_dec_out_if #(
    parameter int SAMPLE_WIDTH = 16
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] filtered_sample;

    modport source (output valid, output filtered_sample, input ready);
    modport sink   (input valid, input filtered_sample, output ready);
endinterface

// File: design/fir_dec_ram.sv
module fir_dec_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 126
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/fir_dec_coef_rom.sv
module fir_dec_coef_rom #(
    parameter int TAPS       = 127,
    parameter int RATIO      = 2,
    parameter int COEF_WIDTH = 18
) (
    input  logic                          i_clk,
    input  logic [$clog2(TAPS)-1:0]       i_addr,
    output logic signed [COEF_WIDTH-1:0]  o_coef
);
    import fir_dec_pkg::*;

    localparam longint HSum = h_sum(TAPS, RATIO);

    logic signed [COEF_WIDTH-1:0] w_rom [TAPS];
    logic signed [COEF_WIDTH-1:0] r_coef;

    // Build the table at elaboration
    for (genvar gi = 0; gi < TAPS; gi++) begin : g_tap
        localparam longint CVal = coef_val(TAPS, RATIO, COEF_WIDTH, gi, HSum);
        assign w_rom[gi] = COEF_WIDTH'(CVal);
    end

    always_ff @(posedge i_clk) begin
        r_coef <= w_rom[i_addr];
    end

    assign o_coef = r_coef;
endmodule

// File: design/fir_dec_mac.sv
module fir_dec_mac #(
    parameter int TAPS         = 127,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 18
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fir_dec_pkg::t_mac_ctl           i_ctl,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_sample,
    input  logic signed [COEF_WIDTH-1:0]    i_coef,
    output logic                            o_done,
    output logic signed [SAMPLE_WIDTH-1:0]  o_result
);
    import fir_dec_pkg::*;

    localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);
    localparam logic signed [ACC_W:0] RndHalf = (ACC_W + 1)'(1) << (COEF_WIDTH - 2);
    localparam logic signed [SAMPLE_WIDTH-1:0] SatMax = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SatMin = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic                     r_prod_last;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_done;
    logic signed [ACC_W:0]    w_rnd;
    logic signed [ACC_W:0]    w_shf;
    logic [ACC_W-SAMPLE_WIDTH+1:0] w_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld  <= 1'b0;
            r_prod_last <= 1'b0;
            r_done      <= 1'b0;
        end else if (i_ctl.start) begin
            r_prod_vld  <= 1'b0;
            r_prod_last <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_prod_vld  <= i_ctl.acc_en;
            r_prod_last <= i_ctl.acc_en & i_ctl.last;
            if (r_prod_vld && r_prod_last) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_sample * i_coef;
        if (i_ctl.start) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Round half up, then saturate
    always_comb begin
        w_rnd = {r_acc[ACC_W-1], r_acc} + RndHalf;
        w_shf = w_rnd >>> (COEF_WIDTH - 1);
        w_hi  = w_shf[ACC_W:SAMPLE_WIDTH-1];
        if (w_hi == '0 || w_hi == '1) begin
            o_result = w_shf[SAMPLE_WIDTH-1:0];
        end else if (w_shf[ACC_W]) begin
            o_result = SatMin;
        end else begin
            o_result = SatMax;
        end
    end

    assign o_done = r_done;
endmodule

// File: design/fir_decimator_windowed_sinc.sv
// Streaming FIR decimator: a TAPS-tap Blackman-windowed sinc low-pass (cutoff 0.9/RATIO of
// input Nyquist, unity DC gain) that emits one rounded, saturated word for the first push
// after reset and every RATIO-th push after that; the decimation phase runs on across pushes
// and is not touched by a clear. The history of the last TAPS-1 samples lives in a circular
// buffer in one single-port-read RAM, with one valid flop per entry so that reset and the
// clear operation empty it without a RAM write (an entry not yet written reads as zero). A
// clear or a push that produces no output leaves the input side ready. A push that produces
// an output holds the input side while the sequencer sweeps all taps through the one RAM read
// port and the one shared multiplier, one tap a cycle, then drains the read, multiply and
// accumulate stages. A finished word waits in the output register while the next inputs are
// taken; the block stalls only if a second result is ready before the first one has gone.
`include "fir_decimator_windowed_sinc_assert.svh"

module fir_decimator_windowed_sinc #(
    parameter int TAPS         = 127,
    parameter int RATIO        = 2,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 18
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    fir_dec_in_if.sink     i_in,
    fir_dec_out_if.source  o_out
);
    import fir_dec_pkg::*;

    localparam int DEPTH = TAPS - 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(TAPS);
    localparam int PW    = $clog2(RATIO);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0]                     r_state, n_state;
    logic [AW-1:0]                  r_wp, n_wp;            // oldest entry / next write slot
    logic [AW-1:0]                  r_rd_addr, n_rd_addr;  // tap sweep read pointer
    logic [KW-1:0]                  r_k, n_k;              // tap index
    logic [PW-1:0]                  r_phase, n_phase;
    logic [DEPTH-1:0]               r_hv, n_hv;            // history entry valid
    logic signed [SAMPLE_WIDTH-1:0] r_x, n_x;              // newest sample during a sweep
    logic                           r_s1_vld;
    logic                           r_s1_last;
    logic                           r_s1_hv;
    logic                           r_out_vld, n_out_vld;
    logic signed [SAMPLE_WIDTH-1:0] r_out_data, n_out_data;

    logic                           w_in_acc;
    logic                           w_load;
    logic                           w_ram_we;
    logic [SAMPLE_WIDTH-1:0]        w_ram_wdata;
    logic [SAMPLE_WIDTH-1:0]        w_ram_rdata;
    logic signed [COEF_WIDTH-1:0]   w_coef;
    logic signed [SAMPLE_WIDTH-1:0] w_opnd;
    t_mac_ctl                       w_ctl;
    logic                           w_mac_done;
    logic signed [SAMPLE_WIDTH-1:0] w_mac_result;
    logic [AW-1:0]                  w_wp_inc;
    logic [AW-1:0]                  w_rd_inc;
    logic [PW-1:0]                  w_phase_inc;

    assign i_in.ready            = (r_state == S_IDLE);
    assign w_in_acc              = i_in.valid && i_in.ready;
    assign o_out.valid           = r_out_vld;
    assign o_out.filtered_sample = r_out_data;

    // Wrapping increments for the ring pointers and the phase counter
    assign w_wp_inc    = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign w_rd_inc    = (r_rd_addr == AW'(DEPTH - 1)) ? '0 : r_rd_addr + 1'b1;
    assign w_phase_inc = (r_phase == PW'(RATIO - 1)) ? '0 : r_phase + 1'b1;

    // Write the pushed word when idle, the held sample at the end of a sweep
    assign w_ram_wdata = (r_state == S_IDLE) ? i_in.sample : r_x;

    // Final tap uses the new sample; empty history entries read as zero
    assign w_opnd = r_s1_last ? r_x : (r_s1_hv ? $signed(w_ram_rdata) : '0);

    always_comb begin
        n_state      = r_state;
        n_wp         = r_wp;
        n_rd_addr    = r_rd_addr;
        n_k          = r_k;
        n_phase      = r_phase;
        n_hv         = r_hv;
        n_x          = r_x;
        w_ram_we     = 1'b0;
        w_load       = 1'b0;
        w_ctl.start  = 1'b0;
        w_ctl.acc_en = r_s1_vld;
        w_ctl.last   = r_s1_last;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.operation == OP_PUSH) begin
                        n_phase = w_phase_inc;
                        if (r_phase != '0) begin
                            // no output due: just store the word
                            w_ram_we   = 1'b1;
                            n_hv[r_wp] = 1'b1;
                            n_wp       = w_wp_inc;
                        end else begin
                            n_x         = i_in.sample;
                            n_rd_addr   = r_wp;
                            n_k         = '0;
                            w_ctl.start = 1'b1;
                            n_state     = S_RUN;
                        end
                    end else begin
                        n_hv = '0;
                    end
                end
            end
            S_RUN: begin
                // issue one tap a cycle, oldest first; hold the index on the last tap
                n_rd_addr = w_rd_inc;
                if (r_k == KW'(TAPS - 1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_DRAIN: begin
                if (w_mac_done && (!r_out_vld || o_out.ready)) begin
                    // hand off the result, then replace the oldest entry
                    w_load     = 1'b1;
                    w_ram_we   = 1'b1;
                    n_hv[r_wp] = 1'b1;
                    n_wp       = w_wp_inc;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld  = r_out_vld && !o_out.ready;
        n_out_data = r_out_data;
        if (w_load) begin
            n_out_vld  = 1'b1;
            n_out_data = w_mac_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wp      <= '0;
            r_rd_addr <= '0;
            r_k       <= '0;
            r_phase   <= '0;
            r_hv      <= '0;
            r_s1_vld  <= 1'b0;
            r_s1_last <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_rd_addr <= n_rd_addr;
            r_k       <= n_k;
            r_phase   <= n_phase;
            r_hv      <= n_hv;
            r_s1_vld  <= (r_state == S_RUN);
            r_s1_last <= (r_state == S_RUN) && (r_k == KW'(TAPS - 1));
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_s1_hv    <= r_hv[r_rd_addr];
        r_out_data <= n_out_data;
    end

    fir_dec_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_wp),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_rd_addr),
        .o_rdata (w_ram_rdata)
    );

    fir_dec_coef_rom #(
        .TAPS       (TAPS),
        .RATIO      (RATIO),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_coef_rom (
        .i_clk  (i_clk),
        .i_addr (r_k),
        .o_coef (w_coef)
    );

    fir_dec_mac #(
        .TAPS         (TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (w_opnd),
        .i_coef   (w_coef),
        .o_done   (w_mac_done),
        .o_result (w_mac_result)
    );

    // An output-due push must start a tap sweep
    `FD_ASSERT_NEXT(a_emit_starts_sweep, i_clk, i_rst_n, w_in_acc && i_in.operation == OP_PUSH && r_phase == '0, r_state == S_RUN)
    // A clear empties the whole history
    `FD_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, w_in_acc && i_in.operation == OP_CLEAR, r_hv == '0)
    // Operands reach the multiplier only while a sweep is in flight
    `FD_ASSERT_NOW(a_operand_in_sweep, i_clk, i_rst_n, r_s1_vld, r_state == S_RUN || r_state == S_DRAIN)
    // The tap index never runs past the last coefficient during a sweep
    `FD_ASSERT_NOW(a_tap_in_range, i_clk, i_rst_n, r_state == S_RUN, r_k <= KW'(TAPS - 1))
endmodule
